// ===== sv/trcw_pkg.sv =====
`default_nettype none

package trcw_pkg;

   // Fixed field widths
   localparam int INT_WIDTH  = 16;
   localparam int DUP_WIDTH  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PKT_WIDTH  = 32;
   localparam int UPPER_W    = 33;

   // Congestion control modes
   localparam logic [1:0] MODE_SS = 2'd0;
   localparam logic [1:0] MODE_CA = 2'd1;
   localparam logic [1:0] MODE_FR = 2'd2;

   // Item kinds
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS  = 2'd2;

   // Register reset values
   localparam logic [INT_WIDTH-1:0]  RESTART_RESET = 16'd100;
   localparam logic [INT_WIDTH-1:0]  THRESH_RESET  = 16'd100;
   localparam logic [PKT_WIDTH-1:0]  TOTAL_RESET   = 32'd1;

   // Duplicate ACK handling
   localparam logic [DUP_WIDTH-1:0] DUP_TRIGGER = 8'd3;
   localparam logic [DUP_WIDTH-1:0] DUP_MAX     = 8'hFF;
   localparam logic [INT_WIDTH:0]   FR_INFLATE  = 17'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/tcp_reno_congestion_window.sv =====
// Reno-style sender congestion control engine.
// Input channel (req_): one item per event, req_kind 0 for an ACK carrying
// req_ack_number, 1 for a receive timeout. Each item gives exactly one result
// on the rsp_ channel: retransmit flag and packet, upper send-window edge,
// mode and completion flag, all taken after the item is applied.
// Each accepted item is latched, checked and then committed to the output
// register; an ACK that advances the send base in congestion avoidance first
// passes through the bit-serial reciprocal divider before the commit.
// One item is in work at a time; the next is accepted as soon as the result
// is loaded into the output register, even while that result still waits.
// A stalled receiver holds the result in the output register; a finished
// item then waits in the engine until the register drains.
// Reset (synchronous) restores the registers to their defaults and the
// window, threshold, send base and mode to their initial values. Register
// writes via csr_ must happen while idle; before the first item they also
// load the window or threshold.
`default_nettype none

module tcp_reno_congestion_window #(
   parameter int SEQ_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_kind,
   input  wire logic [trcw_pkg::PKT_WIDTH-1:0]  req_ack_number,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_retransmit,
   output logic      [trcw_pkg::PKT_WIDTH-1:0]  rsp_retransmit_packet,
   output logic      [trcw_pkg::UPPER_W-1:0]    rsp_window_upper,
   output logic      [1:0]                      rsp_current_mode,
   output logic                                 rsp_done_res,
   input  wire logic                            csr_write_en,
   input  wire logic [trcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [trcw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import trcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   trcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   trcw_dp #(
      .SEQ_WIDTH(SEQ_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_kind              (req_kind),
      .req_ack_number        (req_ack_number),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_retransmit        (rsp_retransmit),
      .rsp_retransmit_packet (rsp_retransmit_packet),
      .rsp_window_upper      (rsp_window_upper),
      .rsp_current_mode      (rsp_current_mode),
      .rsp_done_res          (rsp_done_res)
   );

endmodule

`default_nettype wire

// ===== sv/trcw_div.sv =====
`default_nettype none

// Restoring divider: 2^FRAC_BITS / divisor, one quotient bit per cycle while step is high
module trcw_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          step,
   input  wire logic [trcw_pkg::INT_WIDTH-1:0] divisor,
   output logic      [FRAC_BITS:0]            quotient,
   output logic                               last
);
   import trcw_pkg::*;

   localparam int QW    = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(QW + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAC_BITS);

   logic [INT_WIDTH-1:0] rem_ff,  rem_in;
   logic [QW-1:0]        quot_ff, quot_in;
   logic [CNT_W-1:0]     cnt_ff,  cnt_in;
   logic [INT_WIDTH-1:0] div_ff,  div_in;
   logic [INT_WIDTH:0]   trial;
   logic [INT_WIDTH:0]   diff;
   logic                 fits;

   // One shift and trial subtract per step
   always_comb begin
      trial = {rem_ff, quot_ff[QW-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      if (start) begin
         rem_in  = '0;
         quot_in = QW'(1) << FRAC_BITS;
         cnt_in  = '0;
         // zero divisor counts as one
         div_in  = (divisor == '0) ? INT_WIDTH'(1) : divisor;
      end else if (step) begin
         rem_in  = fits ? diff[INT_WIDTH-1:0] : trial[INT_WIDTH-1:0];
         quot_in = {quot_ff[QW-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign quotient = quot_ff;
   assign last     = (cnt_ff == LAST_CNT);

endmodule

`default_nettype wire

// ===== sv/trcw_dp.sv =====
`default_nettype none

// Congestion state, configuration registers and result registers
module trcw_dp #(
   parameter int SEQ_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire trcw_pkg::cmd_type               cmd,
   output trcw_pkg::status_type                 status,
   input  wire logic                            req_kind,
   input  wire logic [trcw_pkg::PKT_WIDTH-1:0]  req_ack_number,
   input  wire logic                            csr_write_en,
   input  wire logic [trcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [trcw_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                                 rsp_retransmit,
   output logic      [trcw_pkg::PKT_WIDTH-1:0]  rsp_retransmit_packet,
   output logic      [trcw_pkg::UPPER_W-1:0]    rsp_window_upper,
   output logic      [1:0]                      rsp_current_mode,
   output logic                                 rsp_done_res
);
   import trcw_pkg::*;

   localparam int WW = INT_WIDTH + FRAC_BITS;
   localparam logic [WW-1:0] ONE_FIX = WW'(1) << FRAC_BITS;

   // Configuration
   logic [INT_WIDTH-1:0] restart_ff;
   logic [PKT_WIDTH-1:0] total_ff;

   // Latched item
   logic                 kind_ff;
   logic [SEQ_WIDTH-1:0] ack_ff;

   // Congestion state
   logic [1:0]           mode_ff,    mode_in;
   logic [WW-1:0]        win_ff,     win_in;
   logic [INT_WIDTH-1:0] thr_ff,     thr_in;
   logic [SEQ_WIDTH-1:0] base_ff,    base_in;
   logic [DUP_WIDTH-1:0] dup_ff,     dup_in;
   logic                 fin_ff,     fin_in;
   logic                 started_ff;
   logic                 resend;

   logic [FRAC_BITS:0]   quot;
   logic                 div_last;
   logic [PKT_WIDTH-1:0] total_m1;
   logic [SEQ_WIDTH-1:0] last_seq;
   logic                 is_last;
   logic                 ack_new;
   logic [INT_WIDTH-1:0] thr_half;
   logic [DUP_WIDTH-1:0] dup_sat;
   logic [DUP_WIDTH-1:0] dup_wrap;
   logic [INT_WIDTH:0]   fr_int;
   logic [WW-1:0]        fr_win;

   function automatic logic [WW-1:0] sat_add(input logic [WW-1:0] a, input logic [WW-1:0] b);
      logic [WW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WW] ? {WW{1'b1}} : sum[WW-1:0];
   endfunction

   trcw_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .divisor  (win_ff[WW-1:FRAC_BITS]),
      .quotient (quot),
      .last     (div_last)
   );

   // Shared decode of the latched item
   always_comb begin
      total_m1 = total_ff - PKT_WIDTH'(1);
      last_seq = total_m1[SEQ_WIDTH-1:0];
      is_last  = (ack_ff == last_seq);
      ack_new  = (ack_ff >= base_ff);
      thr_half = {1'b0, win_ff[WW-1:FRAC_BITS+1]};
      dup_sat  = (dup_ff == DUP_MAX) ? dup_ff : dup_ff + DUP_WIDTH'(1);
      dup_wrap = dup_ff + DUP_WIDTH'(1);
      fr_int   = {1'b0, thr_half} + FR_INFLATE;
      fr_win   = fr_int[INT_WIDTH] ? {WW{1'b1}} : {fr_int[INT_WIDTH-1:0], {FRAC_BITS{1'b0}}};
      status.need_div = !fin_ff && (kind_ff == KIND_ACK) && !is_last
                        && (mode_ff == MODE_CA) && ack_new;
      status.div_last = div_last;
   end

   // Next state for one item
   always_comb begin
      mode_in = mode_ff;
      win_in  = win_ff;
      thr_in  = thr_ff;
      base_in = base_ff;
      dup_in  = dup_ff;
      fin_in  = fin_ff;
      resend  = 1'b0;
      if (!fin_ff) begin
         if (kind_ff == KIND_TIMEOUT) begin
            thr_in  = thr_half;
            dup_in  = '0;
            mode_in = MODE_SS;
            win_in  = {restart_ff, {FRAC_BITS{1'b0}}};
            resend  = 1'b1;
         end else if (is_last) begin
            fin_in = 1'b1;
         end else begin
            unique case (mode_ff) inside
               MODE_SS, MODE_CA: begin
                  if (ack_new) begin
                     dup_in  = '0;
                     base_in = ack_ff + SEQ_WIDTH'(1);
                     if (mode_ff == MODE_SS) begin
                        win_in = sat_add(win_ff, ONE_FIX);
                        if (win_in >= {thr_ff, {FRAC_BITS{1'b0}}}) begin
                           mode_in = MODE_CA;
                        end
                     end else begin
                        win_in = sat_add(win_ff, WW'(quot));
                     end
                  end else begin
                     dup_in = dup_sat;
                     // third duplicate: halve and enter fast recovery
                     if (dup_sat == DUP_TRIGGER) begin
                        mode_in = MODE_FR;
                        thr_in  = thr_half;
                        win_in  = fr_win;
                        resend  = 1'b1;
                     end
                  end
               end
               MODE_FR: begin
                  if (ack_new) begin
                     base_in = ack_ff + SEQ_WIDTH'(1);
                     win_in  = {thr_ff, {FRAC_BITS{1'b0}}};
                     dup_in  = '0;
                     mode_in = MODE_CA;
                  end else begin
                     win_in = sat_add(win_ff, ONE_FIX);
                     dup_in = dup_wrap;
                     resend = !dup_wrap[0];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff  <= RESTART_RESET;
         total_ff    <= TOTAL_RESET;
         mode_ff     <= MODE_SS;
         win_ff      <= {RESTART_RESET, {FRAC_BITS{1'b0}}};
         thr_ff      <= THRESH_RESET;
         base_ff     <= '0;
         dup_ff      <= '0;
         fin_ff      <= 1'b0;
         started_ff  <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            started_ff <= 1'b1;
         end
         if (cmd.commit) begin
            mode_ff <= mode_in;
            win_ff  <= win_in;
            thr_ff  <= thr_in;
            base_ff <= base_in;
            dup_ff  <= dup_in;
            fin_ff  <= fin_in;
         end else if (csr_write_en) begin
            unique case (csr_index)
               CSR_RESTART_WINDOW: begin
                  restart_ff <= csr_wdata[INT_WIDTH-1:0];
                  if (!started_ff) begin
                     win_ff <= {csr_wdata[INT_WIDTH-1:0], {FRAC_BITS{1'b0}}};
                  end
               end
               CSR_INIT_THRESHOLD: begin
                  // the threshold only takes the value before the first item
                  if (!started_ff) begin
                     thr_ff <= csr_wdata[INT_WIDTH-1:0];
                  end
               end
               CSR_TOTAL_PACKETS: begin
                  total_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Item capture and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         ack_ff  <= req_ack_number[SEQ_WIDTH-1:0];
      end
      if (cmd.commit) begin
         rsp_retransmit        <= resend;
         rsp_retransmit_packet <= PKT_WIDTH'(base_in);
         rsp_window_upper      <= UPPER_W'(base_in) + UPPER_W'(win_in[WW-1:FRAC_BITS]);
         rsp_current_mode      <= mode_in;
         rsp_done_res          <= fin_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/trcw_ctrl.sv =====
`default_nettype none

// Sequencer: capture item, optional divide, then hand over to the result register
module trcw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output trcw_pkg::cmd_type         cmd,
   input  wire trcw_pkg::status_type status
);
   import trcw_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // wait for the result register to drain
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no item is taken while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
